// File: sv/sus_pkg.sv
// Shared types and constants for the sorted unique set engine.
// Depends on nothing; design files use scoped names, testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int DATA_W      = 32;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIRST  = 2'd2,
    CMD_NEXT   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_END     = 2'd3
  } status_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_EXEC = 1'b1
  } phase_t;

  // Control broadcast to the row of cells.
  typedef struct packed {
    logic cmp_en;   // latch compare flags against the incoming value
    logic ins_en;   // open a gap at the insert point and drop the value in
    logic rem_en;   // close the gap at the matching entry
  } sus_ctl_t;

endpackage

`default_nettype wire

// File: sv/sus_in_if.sv
// Command channel interface of the sorted unique set engine.
// Depends on sus_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sus_in_if;
  logic                              valid;
  logic                              ready;
  logic [sus_pkg::CMD_W-1:0]         command;
  logic signed [sus_pkg::DATA_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

`default_nettype wire

// File: sv/sus_out_if.sv
// Result channel interface of the sorted unique set engine.
// Depends on sus_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sus_out_if;
  logic                              valid;
  logic                              ready;
  logic [sus_pkg::STATUS_W-1:0]      status;
  logic signed [sus_pkg::DATA_W-1:0] data_out;
  logic [sus_pkg::CNT_W-1:0]         element_count;
  logic                              is_empty;

  modport source (output valid, status, data_out, element_count, is_empty, input ready);
  modport sink   (input valid, status, data_out, element_count, is_empty, output ready);
endinterface

`default_nettype wire

// File: sv/sus_cell.sv
// One slot of the sorted row: holds an entry and its compare flags.
// Depends on sus_pkg; takes data from its left and right neighbors.
`timescale 1ns / 1ps
`default_nettype none

module sus_cell (
  input  wire                clk,
  input  wire                rst_n,
  input  sus_pkg::sus_ctl_t  ctl,
  input  wire                occ,
  input  sus_pkg::val_t      cmp_val,
  input  sus_pkg::val_t      ins_val,
  input  wire                left_less,
  input  sus_pkg::val_t      left_entry,
  input  sus_pkg::val_t      right_entry,
  output sus_pkg::val_t      entry,
  output logic               less,
  output logic               eq
);

  sus_pkg::val_t entry_r;
  logic          less_r;
  logic          eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      less_r <= 1'b0;
      eq_r   <= 1'b0;
    end else if (ctl.cmp_en) begin
      less_r <= occ && (entry_r < cmp_val);
      eq_r   <= occ && (entry_r == cmp_val);
    end
  end

  // Entries at or above the insert/remove point move one slot.
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !less_r) begin
      entry_r <= left_less ? ins_val : left_entry;
    end else if (ctl.rem_en && !less_r) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign less  = less_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

// File: sv/sus_chain.sv
// Row of sus_cell slots with neighbor links, match reduction and read mux.
// Depends on sus_pkg and sus_cell.
`timescale 1ns / 1ps
`default_nettype none

module sus_chain (
  input  wire                clk,
  input  wire                rst_n,
  input  sus_pkg::sus_ctl_t  ctl,
  input  sus_pkg::cnt_t      count,
  input  sus_pkg::val_t      cmp_val,
  input  sus_pkg::val_t      ins_val,
  input  sus_pkg::idx_t      rd_idx,
  output logic               found,
  output sus_pkg::val_t      rd_data
);

  sus_pkg::val_t                 entry_w [sus_pkg::CAPACITY];
  logic [sus_pkg::CAPACITY-1:0]  less_w;
  logic [sus_pkg::CAPACITY-1:0]  eq_w;

  for (genvar i = 0; i < sus_pkg::CAPACITY; i++) begin : g_cell
    logic          occ;
    logic          l_less;
    sus_pkg::val_t l_entry;
    sus_pkg::val_t r_entry;

    assign occ = sus_pkg::CNT_W'(i) < count;

    // Slot zero sees a virtual smaller neighbor, so a gap there takes the new value.
    if (i == 0) begin : g_head
      assign l_less  = 1'b1;
      assign l_entry = ins_val;
    end else begin : g_body
      assign l_less  = less_w[i-1];
      assign l_entry = entry_w[i-1];
    end

    if (i == sus_pkg::CAPACITY - 1) begin : g_tail
      assign r_entry = entry_w[i];
    end else begin : g_mid
      assign r_entry = entry_w[i+1];
    end

    sus_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .occ         (occ),
      .cmp_val     (cmp_val),
      .ins_val     (ins_val),
      .left_less   (l_less),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .entry       (entry_w[i]),
      .less        (less_w[i]),
      .eq          (eq_w[i])
    );
  end

  assign found   = |eq_w;
  assign rd_data = entry_w[rd_idx];

endmodule

`default_nettype wire

// File: sv/sorted_unique_set_engine.sv
// Top level of the sorted unique set engine: handshake, sequencing, cursor.
// Depends on sus_pkg, sus_in_if, sus_out_if and sus_chain.
//
//   channel  | direction | handshake     | word
//   in_ch    | in        | valid / ready | command, value
//   out_ch   | out       | valid / ready | status, data_out, element_count, is_empty
//
// A command is accepted in the idle phase, which broadcasts the value and latches
// per-slot compare flags; the execute phase shifts the row (or reads the cursor
// slot) and loads the result register. No word is accepted during execute.
// Reset clears the count, the cursor, the held command and the handshake state;
// slot contents are left as they are and only slots below the count are ever read.
// A stalled result holds in its register; one more command may then be accepted
// and hold in its execute phase, compare flags latched, until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_set_engine (
  input  wire        clk,
  input  wire        rst_n,
  sus_in_if.sink     in_ch,
  sus_out_if.source  out_ch
);

  // Phase and held command.
  sus_pkg::phase_t  phase_r, phase_nxt;
  sus_pkg::cmd_t    cmd_r;
  sus_pkg::val_t    value_r;

  // Set state.
  sus_pkg::cnt_t    count_r, count_nxt;
  sus_pkg::idx_t    cursor_r, cursor_nxt;
  logic             cur_act_r, cur_act_nxt;

  // Result register.
  logic                          out_valid_r;
  sus_pkg::status_t              out_status_r, out_status_nxt;
  logic signed [sus_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  sus_pkg::cnt_t                 out_count_r;
  logic                          out_empty_r;

  sus_pkg::sus_ctl_t ctl;
  logic              in_acc;
  logic              fire;
  logic              found;
  logic              full;
  logic              hit;
  sus_pkg::cnt_t     trav_idx;
  sus_pkg::val_t     rd_data;
  sus_pkg::val_t     in_val;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_val = sus_pkg::val_t'(in_ch.value[sus_pkg::VALUE_WIDTH-1:0]);
  assign fire   = (phase_r == sus_pkg::PH_EXEC) && (!out_valid_r || out_ch.ready);
  assign full   = count_r == sus_pkg::CNT_W'(sus_pkg::CAPACITY);

  // Traverse slot: restart from the head unless a cursor is live on a next.
  assign trav_idx = ((cmd_r == sus_pkg::CMD_FIRST) || !cur_act_r) ? '0
                    : sus_pkg::CNT_W'(cursor_r) + sus_pkg::CNT_W'(1);
  assign hit      = trav_idx < count_r;

  sus_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .count   (count_r),
    .cmp_val (in_val),
    .ins_val (value_r),
    .rd_idx  (trav_idx[sus_pkg::IDX_W-1:0]),
    .found   (found),
    .rd_data (rd_data)
  );

  // Phase sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sus_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    in_ch.ready  = 1'b0;
    unique case (phase_r)
      sus_pkg::PH_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          phase_nxt = sus_pkg::PH_EXEC;
        end
      end
      sus_pkg::PH_EXEC: begin
        if (fire) begin
          phase_nxt = sus_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = sus_pkg::PH_IDLE;
    endcase
  end

  // Latch the command; the cells latch their compare flags on the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= sus_pkg::CMD_ADD;
    end else if (in_acc) begin
      cmd_r <= sus_pkg::cmd_t'(in_ch.command);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      value_r <= in_val;
    end
  end

  // Execute phase: decide status, shift the row, advance the cursor.
  always_comb begin
    ctl            = '0;
    ctl.cmp_en     = in_acc;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    cur_act_nxt    = cur_act_r;
    out_status_nxt = sus_pkg::ST_DONE;
    out_data_nxt   = '0;
    unique case (cmd_r)
      sus_pkg::CMD_ADD: begin
        cursor_nxt  = '0;
        cur_act_nxt = 1'b0;
        if (found) begin
          out_status_nxt = sus_pkg::ST_IGNORED;
        end else if (full) begin
          out_status_nxt = sus_pkg::ST_FULL;
        end else begin
          ctl.ins_en = fire;
          count_nxt  = count_r + sus_pkg::CNT_W'(1);
        end
      end
      sus_pkg::CMD_REMOVE: begin
        cursor_nxt  = '0;
        cur_act_nxt = 1'b0;
        if (!found) begin
          out_status_nxt = sus_pkg::ST_IGNORED;
        end else begin
          ctl.rem_en = fire;
          count_nxt  = count_r - sus_pkg::CNT_W'(1);
        end
      end
      sus_pkg::CMD_FIRST, sus_pkg::CMD_NEXT: begin
        if (hit) begin
          cur_act_nxt  = 1'b1;
          cursor_nxt   = trav_idx[sus_pkg::IDX_W-1:0];
          out_data_nxt = sus_pkg::DATA_W'(rd_data);
        end else begin
          cur_act_nxt    = 1'b0;
          cursor_nxt     = '0;
          out_status_nxt = sus_pkg::ST_END;
        end
      end
      default: begin
        out_status_nxt = sus_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cursor_r  <= '0;
      cur_act_r <= 1'b0;
    end else if (fire) begin
      count_r   <= count_nxt;
      cursor_r  <= cursor_nxt;
      cur_act_r <= cur_act_nxt;
    end
  end

  // Result register: load on execute, drop when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_count_r  <= count_nxt;
      out_empty_r  <= count_nxt == '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.data_out      = out_data_r;
  assign out_ch.element_count = out_count_r;
  assign out_ch.is_empty      = out_empty_r;

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sus_pkg::CNT_W'(sus_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_insert_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_en |-> (!found && !full))
    else $error("insert issued on duplicate or full store");

  a_shift_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem_en |=> (count_r == $past(count_r) - sus_pkg::CNT_W'(1)))
    else $error("remove shift without count decrement");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (phase_r == sus_pkg::PH_EXEC))
    else $error("accepted word not executed");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the sorted unique set engine: a directed table,
// then random command words, checked per typed row or by a cycle-free set predictor.
// Depends on sus_pkg, sus_in_if, sus_out_if and sorted_unique_set_engine.
`timescale 1ns / 1ps

module testbench;
  import sus_pkg::*;

  localparam int   LIMIT_CYCLES    = 400000;
  localparam int   DRAIN_CYCLES    = 20;
  localparam int   WORDS_PER_PHASE = 306;
  localparam val_t VMAX            = 32'sh7FFF_FFFF;
  localparam val_t VMIN            = 32'sh8000_0000;

  // One expected result word.
  typedef struct {
    status_t status;
    val_t    data;
    cnt_t    count;
    logic    empty;
  } set_result_t;

  // One row of the directed table; reps > 1 adds consecutive values.
  typedef struct {
    cmd_t    cmd;
    val_t    value;
    int      reps;
    bit      typed;
    status_t st;
    val_t    data;
    int      count;
    bit      empty;
  } stim_row_t;

  logic clk;
  logic rst_n;

  sus_in_if  in_ch ();
  sus_out_if out_ch ();

  sorted_unique_set_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: the stored set, ascending, and the walk cursor.
  val_t set_vals [CAPACITY];
  int   set_count;
  int   sel_pos;
  bit   sel_valid;

  set_result_t pending_results [$];
  int          error_count;
  int          cycle_count;

  // Idling knobs, percent of cycles.
  int send_idle;
  int stall_pct;

  // Random generator state.
  int walk_left;
  bit grow_mode;
  int rnd_count;

  // Directed table. Typed rows carry the expected word; the others use the predictor.
  stim_row_t dir_rows [13] = '{
    // traverse-next on an empty store with nothing selected: end status
    '{CMD_NEXT,   32'sd0,          1, 1'b1, ST_END,     32'sd0, 0, 1'b1},
    // remove from an empty store: absent, ignored
    '{CMD_REMOVE, 32'sd0,          1, 1'b1, ST_IGNORED, 32'sd0, 0, 1'b1},
    '{CMD_ADD,    VMAX,            1, 1'b1, ST_DONE,    32'sd0, 1, 1'b0},
    '{CMD_ADD,    VMIN,            1, 1'b1, ST_DONE,    32'sd0, 2, 1'b0},
    // duplicate add: ignored
    '{CMD_ADD,    VMAX,            1, 1'b1, ST_IGNORED, 32'sd0, 2, 1'b0},
    // add cleared the cursor, so next starts from the first entry
    '{CMD_NEXT,   32'sh5A5A_5A5A,  1, 1'b1, ST_DONE,    VMIN,   2, 1'b0},
    '{CMD_NEXT,   32'shA5A5_A5A5,  1, 1'b1, ST_DONE,    VMAX,   2, 1'b0},
    // walk past the last entry
    '{CMD_NEXT,   32'sd0,          1, 1'b1, ST_END,     32'sd0, 2, 1'b0},
    '{CMD_REMOVE, VMIN,            1, 1'b1, ST_DONE,    32'sd0, 1, 1'b0},
    // fill up: -7 .. 7 on top of the max value
    '{CMD_ADD,    -32'sd7,        15, 1'b0, ST_DONE,    32'sd0, 0, 1'b0},
    // add when full: dropped
    '{CMD_ADD,    32'sd8,          1, 1'b1, ST_FULL,    32'sd0, 16, 1'b0},
    '{CMD_FIRST,  32'shFFFF_FFFF,  1, 1'b1, ST_DONE,    -32'sd7, 16, 1'b0},
    '{CMD_REMOVE, VMAX,            1, 1'b1, ST_DONE,    32'sd0, 15, 1'b0}
  };

  // Apply one command to the predicted set and return the word it produces.
  function automatic set_result_t predict_set_op(cmd_t c, val_t v);
    set_result_t r;
    int          pos;
    int          k;
    int          nxt;
    bit          hit;
    r.status = ST_DONE;
    r.data   = '0;
    if (c == CMD_ADD || c == CMD_REMOVE) begin
      pos = 0;
      while (pos < set_count && set_vals[pos] < v) pos++;
      hit       = (pos < set_count) && (set_vals[pos] == v);
      // any add or remove drops the selection, whatever its outcome
      sel_valid = 1'b0;
      sel_pos   = 0;
      if (c == CMD_ADD) begin
        if (hit) begin
          r.status = ST_IGNORED;
        end else if (set_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = set_count; k > pos; k--) set_vals[k] = set_vals[k-1];
          set_vals[pos] = v;
          set_count++;
        end
      end else begin
        if (!hit) begin
          r.status = ST_IGNORED;
        end else begin
          for (k = pos; k + 1 < set_count; k++) set_vals[k] = set_vals[k+1];
          set_count--;
        end
      end
    end else begin
      // next with nothing selected behaves as traverse from start
      nxt = (c == CMD_FIRST || !sel_valid) ? 0 : sel_pos + 1;
      if (nxt < set_count) begin
        sel_valid = 1'b1;
        sel_pos   = nxt;
        r.data    = set_vals[nxt];
      end else begin
        sel_valid = 1'b0;
        sel_pos   = 0;
        r.status  = ST_END;
      end
    end
    r.count = cnt_t'(set_count);
    r.empty = (set_count == 0);
    return r;
  endfunction

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver backpressure, changed at the falling edge only.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk) begin : result_check
    set_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d data_out %0d count %0d",
               out_ch.status, out_ch.data_out, out_ch.element_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.data_out !== want.data) begin
          $error("data_out: expected %0d, got %0d", want.data, out_ch.data_out);
          error_count++;
        end
        if (out_ch.element_count !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count,
                 out_ch.element_count);
          error_count++;
        end
        if (out_ch.is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, out_ch.is_empty);
          error_count++;
        end
      end
    end
  end

  // Drive one command word, starting at a falling edge; return at a falling
  // edge after it was accepted. Valid is only lowered during a sender gap.
  task automatic send_word(cmd_t c, val_t v, bit typed, set_result_t typed_res);
    set_result_t pred;
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.command = c;
    in_ch.value   = v;
    do @(posedge clk); while (!in_ch.ready);
    // predict at acceptance so the set stays in step even for typed rows
    pred = predict_set_op(c, v);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // Pick a random command word. Values come mostly from a small pool so that
  // duplicates, hits on remove and a full store happen often; grow and shrink
  // modes alternate to sweep the count between empty and full.
  task automatic pick_word(output cmd_t c, output val_t v);
    int r;
    int vr;
    rnd_count++;
    if (rnd_count % 48 == 0) grow_mode = ~grow_mode;
    if (walk_left > 0) begin
      c = CMD_NEXT;
      walk_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < (grow_mode ? 60 : 20)) begin
        c = CMD_ADD;
      end else if (r < 80) begin
        c = CMD_REMOVE;
      end else if (r < 88) begin
        c = CMD_FIRST;
        // half the time walk the whole set past its end, then one more next
        if ($urandom_range(0, 1)) walk_left = set_count + 1;
      end else begin
        c = CMD_NEXT;
      end
    end
    vr = $urandom_range(0, 9);
    if (c == CMD_FIRST || c == CMD_NEXT || vr == 9) begin
      v = val_t'($urandom);
    end else if (vr == 8) begin
      v = $urandom_range(0, 1) ? VMAX : VMIN;
    end else begin
      v = val_t'($urandom_range(0, 23)) - 32'sd12;
    end
  endtask

  initial begin : stimulus
    int          row;
    int          rep;
    int          ph;
    int          n;
    int          idle_cfg [4];
    int          stall_cfg [4];
    cmd_t        c;
    val_t        v;
    set_result_t typed_res;

    // phases: no idling, sender idle, receiver stalling, both
    idle_cfg  = '{0, 85, 0, 22};
    stall_cfg = '{0, 0, 85, 22};

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    send_idle     = 0;
    stall_pct     = 0;
    set_count     = 0;
    sel_pos       = 0;
    sel_valid     = 1'b0;
    walk_left     = 0;
    grow_mode     = 1'b1;
    rnd_count     = 0;
    error_count   = 0;
    cycle_count   = 0;

    // hold reset, release at a falling edge
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (row = 0; row < 13; row++) begin
      typed_res = '{dir_rows[row].st, dir_rows[row].data,
                    cnt_t'(dir_rows[row].count), dir_rows[row].empty};
      for (rep = 0; rep < dir_rows[row].reps; rep++) begin
        send_word(dir_rows[row].cmd, dir_rows[row].value + rep,
                  dir_rows[row].typed, typed_res);
      end
    end

    // random words, one block per idling phase
    for (ph = 0; ph < 4; ph++) begin
      send_idle = idle_cfg[ph];
      stall_pct = stall_cfg[ph];
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        pick_word(c, v);
        send_word(c, v, 1'b0, typed_res);
      end
    end

    // drop valid, stop stalling and drain the outstanding results
    in_ch.valid = 1'b0;
    stall_pct   = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/sus_pkg.sv
sv/sus_in_if.sv
sv/sus_out_if.sv
sv/sus_cell.sv
sv/sus_chain.sv
sv/sorted_unique_set_engine.sv
test/testbench.sv
